[design/assert_macros.svh]
// assertion macros shared by the sector table design
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on i_clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/stl_pkg.sv]
// types, codes and helper functions for the sector table relayout block
// no dependencies; imported by every module of the block
package stl_pkg;

    localparam int DEFAULT_DEPTH = 4096;
    localparam int SECTOR_BYTES  = 2048;
    localparam int SECTOR_SHIFT  = $clog2(SECTOR_BYTES);
    localparam logic [31:0] SECTOR_MASK = 32'(SECTOR_BYTES - 1);

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int SEC_W   = 24;
    localparam int SIZE_W  = 32;
    localparam int OFF_W   = 32;
    localparam int KIND_W  = 2;
    localparam int PADDR_W = 3;

    localparam logic [SEC_W-1:0]  TERMINATOR = 24'hFFFFFF;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 32'hFF000000;
    localparam logic [CNT_W-1:0]  SKIP_RESET = 13'd18;

    // action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TERM  = 2'd2;

    // entry kinds
    localparam logic [KIND_W-1:0] KIND_FILE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZEROS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_SKIP_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  entry_index;
        logic [SEC_W-1:0]  entry_sector;
        logic [SIZE_W-1:0] entry_size;
        logic [OFF_W-1:0]  new_offset;
        logic              is_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SEC_W-1:0]  sector;
        logic [SIZE_W-1:0] size;
        logic [KIND_W-1:0] kind;
        logic              changed;
        logic [OFF_W-1:0]  offset_out;
        logic [SEC_W-1:0]  export_sector;
        logic [CNT_W-1:0]  entry_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RELAYOUT,
        S_READ,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic write_item;
        logic rl_init;
        logic rl_step;
        logic use_rl;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic rl_needed;
        logic rl_done;
        logic out_free;
    } t_stat;

    function automatic logic [KIND_W-1:0] classify(input logic [SEC_W-1:0] sec,
                                                   input logic [SIZE_W-1:0] sz);
        logic [KIND_W-1:0] k;
        if ((sec != '0) && (sz < SIZE_LIMIT) && (sz != '0)) begin
            k = KIND_FILE;
        end else if ((sec == '0) && (sz == '0)) begin
            k = KIND_ZEROS;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    // sectors taken by a file, rounded up
    function automatic logic [SEC_W-1:0] sectors_for(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] q;
        q = (sz >> SECTOR_SHIFT) + SIZE_W'(|(sz & SECTOR_MASK));
        return q[SEC_W-1:0];
    endfunction

endpackage

[design/stl_ctrl.sv]
// controller state machine for the sector table relayout block
// depends on stl_pkg and assert_macros.svh
`include "assert_macros.svh"

module stl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  stl_pkg::t_stat i_stat,
    output stl_pkg::t_cmd  o_cmd
);
    import stl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.write_item = 1'b1;
                o_cmd.rl_init    = 1'b1;
                priority if (!i_stat.in_range) begin
                    n_state = S_RESP;
                end else if (i_stat.rl_needed) begin
                    n_state = S_RELAYOUT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RELAYOUT: begin
                o_cmd.use_rl  = 1'b1;
                o_cmd.rl_step = 1'b1;
                if (i_stat.rl_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_to_decode, i_in_valid && !o_in_stall, r_state == S_DECODE, "accepted transaction did not reach decode")
    `ASSERT_NEXT(a_result_frees, o_cmd.out_load, !o_in_stall, "block not idle after result load")

endmodule

[design/stl_dp.sv]
// datapath of the sector table relayout block: entry memories, relayout walk,
// item and output registers; depends on stl_pkg and assert_macros.svh
`include "assert_macros.svh"

module stl_dp #(
    parameter int DEPTH = stl_pkg::DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stl_pkg::t_in_item          i_in_data,
    input  logic [stl_pkg::CNT_W-1:0]  i_skip_count,
    input  stl_pkg::t_cmd              i_cmd,
    output stl_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    output stl_pkg::t_out_item         o_out_data,
    input  logic                       i_out_stall
);
    import stl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SEC_W-1:0]  sector_mem  [DEPTH];
    logic [SIZE_W-1:0] size_mem    [DEPTH];
    logic [KIND_W-1:0] kind_mem    [DEPTH];
    logic              changed_mem [DEPTH];
    logic [OFF_W-1:0]  offset_mem  [DEPTH];

    t_in_item          r_item;
    logic [CNT_W-1:0]  r_count;
    logic [1:0]        r_status;
    logic              r_err;
    logic [CNT_W-1:0]  r_ptr;
    logic              r_pend;
    logic [AW-1:0]     r_pend_addr;
    logic              r_first;
    logic [SEC_W-1:0]  r_run;
    logic [SEC_W-1:0]  r_rd_sector;
    logic [SIZE_W-1:0] r_rd_size;
    logic [KIND_W-1:0] r_rd_kind;
    logic              r_rd_changed;
    logic [OFF_W-1:0]  r_rd_offset;
    logic              r_out_valid;
    t_out_item         r_out_data;
    t_out_item         n_out_data;

    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     rd_addr;
    logic              is_load;
    logic              is_set;
    logic              in_depth;
    logic              in_range;
    logic              ptr_live;
    logic [SEC_W-1:0]  run_cur;
    logic [SEC_W-1:0]  run_next;
    logic              load_we;
    logic              set_we;
    logic              rl_we;
    logic              sec_we;
    logic [AW-1:0]     sec_wa;
    logic [SEC_W-1:0]  sec_wd;
    logic              is_final;

    assign item_addr = AW'(r_item.entry_index);
    assign is_load   = (r_item.action == ACT_LOAD);
    assign is_set    = (r_item.action == ACT_SET);
    assign in_depth  = (32'(r_item.entry_index) < DEPTH);
    assign in_range  = is_load ? in_depth : ({1'b0, r_item.entry_index} < r_count);
    assign ptr_live  = (r_ptr < r_count);
    assign rd_addr   = i_cmd.use_rl ? AW'(r_ptr) : item_addr;

    assign o_stat.in_range  = in_range;
    assign o_stat.rl_needed = is_set && (i_skip_count < r_count);
    assign o_stat.rl_done   = !ptr_live && !r_pend;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // running sector starts from the first walked entry's own sector
    assign run_cur  = r_first ? r_rd_sector : r_run;
    assign run_next = (r_rd_kind == KIND_FILE) ? (run_cur + sectors_for(r_rd_size)) : run_cur;

    assign load_we = i_cmd.write_item && is_load && in_depth;
    assign set_we  = i_cmd.write_item && is_set && in_range;
    assign rl_we   = i_cmd.rl_step && r_pend &&
                     ((r_rd_kind == KIND_FILE) || (r_rd_kind == KIND_OTHER));
    assign sec_we  = load_we || rl_we;
    assign sec_wa  = load_we ? item_addr : r_pend_addr;
    assign sec_wd  = load_we ? r_item.entry_sector : run_cur;

    always_ff @(posedge i_clk) begin
        if (sec_we) begin
            sector_mem[sec_wa] <= sec_wd;
        end
        r_rd_sector <= sector_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we || set_we) begin
            size_mem[item_addr] <= r_item.entry_size;
        end
        r_rd_size <= size_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            kind_mem[item_addr] <= classify(r_item.entry_sector, r_item.entry_size);
        end
        r_rd_kind <= kind_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we || set_we) begin
            changed_mem[item_addr] <= set_we;
        end
        r_rd_changed <= changed_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (load_we || set_we) begin
            offset_mem[item_addr] <= set_we ? r_item.new_offset : '0;
        end
        r_rd_offset <= offset_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.write_item) begin
            r_err <= !in_range;
            priority if (!in_range) begin
                r_status <= ST_RANGE;
            end else if (is_load && r_item.is_last && (r_item.entry_sector != TERMINATOR)) begin
                r_status <= ST_TERM;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.rl_step) begin
            r_pend_addr <= AW'(r_ptr);
            if (r_pend) begin
                r_run <= run_next;
            end
        end
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_we && r_item.is_last) begin
                r_count <= CNT_W'(r_item.entry_index) + CNT_W'(1);
            end
            if (i_cmd.rl_init) begin
                r_ptr   <= i_skip_count;
                r_pend  <= 1'b0;
                r_first <= 1'b1;
            end else if (i_cmd.rl_step) begin
                r_pend <= ptr_live;
                if (ptr_live) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                if (r_pend) begin
                    r_first <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign is_final = (r_count != '0) && ({1'b0, r_item.entry_index} == (r_count - CNT_W'(1)));

    always_comb begin
        n_out_data             = '0;
        n_out_data.status      = r_status;
        n_out_data.entry_count = r_count;
        if (!r_err) begin
            n_out_data.sector        = r_rd_sector;
            n_out_data.size          = r_rd_size;
            n_out_data.kind          = r_rd_kind;
            n_out_data.changed       = r_rd_changed;
            n_out_data.offset_out    = r_rd_offset;
            n_out_data.export_sector = is_final ? TERMINATOR : r_rd_sector;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_IMPL(a_count_in_depth, 1'b1, 32'(r_count) <= DEPTH, "entry count beyond table depth")
    `ASSERT_IMPL(a_walk_bounded, r_pend, r_ptr <= r_count, "relayout pointer ran past entry count")
    `ASSERT_NEXT(a_count_hold, !i_cmd.write_item, $stable(r_count), "entry count moved without a load")

endmodule

[design/sector_table_relayout_core.sv]
// sector table relayout top level: apb register plus the ctrl/dp pair; depends on stl_pkg
// load/query: the result passes the decode, read and respond states; an out-of-range index
// skips read; set_size with skip_count under entry_count adds a relayout walk, one entry
// per cycle; the next transaction is taken while a result waits
// synchronous active-low reset clears entry count, fsm and output valid; tables keep their
// contents; skip_count resets to 18
module sector_table_relayout_core #(
    parameter int DEPTH = stl_pkg::DEFAULT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  stl_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output stl_pkg::t_out_item           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import stl_pkg::*;

    logic [CNT_W-1:0] r_skip_count;
    logic             cfg_wr;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count <= SKIP_RESET;
        end else if (cfg_wr && (paddr[PADDR_W-1] == REG_SKIP_COUNT)) begin
            r_skip_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_SKIP_COUNT) ? 32'(r_skip_count) : '0;

    stl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    stl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_skip_count (r_skip_count),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
